### rtl/cosine_similarity_unit_macros.svh
// assertion macros used by the checker file of the cosine similarity unit
`ifndef COSINE_SIMILARITY_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_UNIT_MACROS_SVH

// clocked property, switched off while reset is high
`define CSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define CSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/csu_pkg.sv
// types and fixed constants of the cosine similarity unit
package csu_pkg;

   localparam int DataW    = 16;           // element width, signed
   localparam int OutW     = 16;           // similarity field width
   localparam int AccW     = 35;           // accumulator width
   localparam int ProdW    = 2 * AccW;     // product of the two sums of squares
   localparam int SqRemW   = AccW + 3;     // square root partial remainder
   localparam int CntW     = 6;            // back end step counter
   localparam int MulSteps  = AccW;        // one multiplier bit per step
   localparam int SqrtSteps = AccW;        // one root bit per step

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_SETTLE,
      ST_LOAD,
      ST_MULT,
      ST_SQRT,
      ST_DIVIDE,
      ST_RESULT
   } csu_state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic mul_step;
      logic sqrt_step;
      logic div_step;
      logic result_load;
   } csu_cmd_type;

endpackage

### rtl/csu_if.sv
// request and response channel interfaces of the cosine similarity unit
interface csu_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [csu_pkg::DataW-1:0]    x_value;
   logic signed [csu_pkg::DataW-1:0]    y_value;
   logic                                last;

   modport source (output valid, output x_value, output y_value, output last, input ready);
   modport sink   (input valid, input x_value, input y_value, input last, output ready);
endinterface

interface csu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [csu_pkg::OutW-1:0]     similarity;
   logic                                zero_norm;
   logic                                overflow;

   modport source (output valid, output similarity, output zero_norm, output overflow,
                   input ready);
   modport sink   (input valid, input similarity, input zero_norm, input overflow,
                   output ready);
endinterface

### rtl/cosine_similarity_unit.sv
// top level of the cosine similarity unit
// req_chan carries one element pair (x_value, y_value) per transaction, last marking
// the final pair of a vector; rsp_chan carries one result per vector (similarity in
// Q1.FRAC_BITS, zero_norm, overflow).
// while a vector streams in, one pair is taken every cycle.
// after the last pair, req_chan.ready stays low while the back end runs: it settles the
// accumulators, loads the back end, forms the product of the sums of squares in the
// bit-serial multiplier, takes its square root (one root bit a cycle), runs the divider
// and then loads the result into the output register once that register is free.
// pairs beyond MAX_LEN are dropped from the sums and flag overflow.
// reset clears the accumulators, the state machine and rsp_chan.valid.
// a stalled receiver holds the result in the output register; the next vector is
// still accepted, and only its own result waits until the register is free.
module cosine_similarity_unit #(
   parameter int MAX_LEN   = 64,
   parameter int FRAC_BITS = 14
) (
   input logic         clock,
   input logic         reset,
   csu_req_if.sink     req_chan,
   csu_rsp_if.source   rsp_chan
);

   csu_pkg::csu_cmd_type cmd;

   csu_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .rsp_ready (rsp_chan.ready),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   csu_dp #(
      .MAX_LEN   (MAX_LEN),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .x_value    (req_chan.x_value),
      .y_value    (req_chan.y_value),
      .similarity (rsp_chan.similarity),
      .zero_norm  (rsp_chan.zero_norm),
      .overflow   (rsp_chan.overflow)
   );

endmodule

### rtl/csu_ctrl.sv
// controller state machine of the cosine similarity unit
module csu_ctrl #(
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  logic                 rsp_ready,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output csu_pkg::csu_cmd_type cmd
);

   localparam logic [csu_pkg::CntW-1:0] MulLast  = csu_pkg::CntW'(csu_pkg::MulSteps - 1);
   localparam logic [csu_pkg::CntW-1:0] SqrtLast = csu_pkg::CntW'(csu_pkg::SqrtSteps - 1);
   localparam logic [csu_pkg::CntW-1:0] DivLast  = csu_pkg::CntW'(FRAC_BITS - 1);

   csu_pkg::csu_state_type state_ff, state_in;
   logic [csu_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csu_pkg::ST_ACCUM: begin
            if (req_valid && req_last) begin
               state_in = csu_pkg::ST_SETTLE;
            end
         end
         csu_pkg::ST_SETTLE: state_in = csu_pkg::ST_LOAD;
         csu_pkg::ST_LOAD:   state_in = csu_pkg::ST_MULT;
         csu_pkg::ST_MULT: begin
            if (cnt_ff == MulLast) begin
               state_in = csu_pkg::ST_SQRT;
            end
         end
         csu_pkg::ST_SQRT: begin
            if (cnt_ff == SqrtLast) begin
               state_in = csu_pkg::ST_DIVIDE;
            end
         end
         csu_pkg::ST_DIVIDE: begin
            if (cnt_ff == DivLast) begin
               state_in = csu_pkg::ST_RESULT;
            end
         end
         csu_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = csu_pkg::ST_ACCUM;
            end
         end
         default: state_in = csu_pkg::ST_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         csu_pkg::ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         csu_pkg::ST_SETTLE: ;
         csu_pkg::ST_LOAD:   cmd.load      = 1'b1;
         csu_pkg::ST_MULT:   cmd.mul_step  = 1'b1;
         csu_pkg::ST_SQRT:   cmd.sqrt_step = 1'b1;
         csu_pkg::ST_DIVIDE: cmd.div_step  = 1'b1;
         csu_pkg::ST_RESULT: cmd.result_load = out_free;
         default: ;
      endcase
   end

   // step counter restarts on every state change
   always_comb begin
      if (state_in != state_ff || !(cmd.mul_step || cmd.sqrt_step || cmd.div_step)) begin
         cnt_in = '0;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csu_pkg::ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/csu_dp.sv
// datapath of the cosine similarity unit: accumulators, multiplier, square root, divider
module csu_dp #(
   parameter int MAX_LEN   = 64,
   parameter int FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  csu_pkg::csu_cmd_type              cmd,
   input  logic signed [csu_pkg::DataW-1:0]  x_value,
   input  logic signed [csu_pkg::DataW-1:0]  y_value,
   output logic signed [csu_pkg::OutW-1:0]   similarity,
   output logic                              zero_norm,
   output logic                              overflow
);

   localparam int AccW   = csu_pkg::AccW;
   localparam int ProdW  = csu_pkg::ProdW;
   localparam int SqRemW = csu_pkg::SqRemW;
   localparam int OutW   = csu_pkg::OutW;
   localparam int MulW   = 2 * csu_pkg::DataW;
   localparam int CountW = $clog2(MAX_LEN + 1);
   localparam int QW     = FRAC_BITS + 1;
   localparam int SimW   = (FRAC_BITS + 2 > OutW) ? FRAC_BITS + 2 : OutW;
   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LEN);
   localparam logic [QW-1:0]     QOne     = {1'b1, {FRAC_BITS{1'b0}}};

   // first stage: products of the accepted pair
   logic                   s1_valid_ff, s1_valid_in;
   logic signed [MulW-1:0] s1_dot_ff, s1_dot_in;
   logic [MulW-2:0]        s1_xx_ff, s1_xx_in;
   logic [MulW-2:0]        s1_yy_ff, s1_yy_in;
   logic signed [MulW-1:0] xx_full, yy_full;

   // accumulators
   logic signed [AccW-1:0] dot_sum_ff, dot_sum_in;
   logic [AccW-1:0]        xsq_ff, xsq_in;
   logic [AccW-1:0]        ysq_ff, ysq_in;
   logic [CountW-1:0]      count_ff, count_in;
   logic                   ovf_seen_ff, ovf_seen_in;
   logic signed [AccW:0]   dot_wide;
   logic [AccW:0]          xsq_wide, ysq_wide;

   // back end
   logic [AccW-1:0]        ma_ff, ma_in;
   logic [AccW-1:0]        mb_ff, mb_in;
   logic [ProdW-1:0]       prod_ff, prod_in;
   logic [AccW-1:0]        root_ff, root_in;
   logic [SqRemW-1:0]      sqrem_ff, sqrem_in;
   logic [AccW-1:0]        mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [AccW-1:0]        drem_ff, drem_in;
   logic [FRAC_BITS-1:0]   q_ff, q_in;
   logic                   ovf_ff, ovf_in;
   logic [SqRemW-1:0]      sq_try, sq_trial;
   logic [AccW:0]          div_try, div_den;

   // result register
   logic [OutW-1:0]        sim_ff, sim_in;
   logic                   zero_ff, zero_in;
   logic                   ovfo_ff, ovfo_in;
   logic [QW-1:0]          q_full;
   logic signed [SimW-1:0] sim_full;

   assign xx_full = MulW'(x_value) * MulW'(x_value);
   assign yy_full = MulW'(y_value) * MulW'(y_value);

   always_comb begin
      s1_valid_in = cmd.accept;
      s1_dot_in   = MulW'(x_value) * MulW'(y_value);
      s1_xx_in    = xx_full[MulW-2:0];
      s1_yy_in    = yy_full[MulW-2:0];
   end

   // saturating accumulation, pairs beyond the length limit only flag overflow
   always_comb begin
      dot_wide    = {dot_sum_ff[AccW-1], dot_sum_ff}
                    + {{(AccW + 1 - MulW){s1_dot_ff[MulW-1]}}, s1_dot_ff};
      xsq_wide    = {1'b0, xsq_ff} + {{(AccW + 2 - MulW){1'b0}}, s1_xx_ff};
      ysq_wide    = {1'b0, ysq_ff} + {{(AccW + 2 - MulW){1'b0}}, s1_yy_ff};
      dot_sum_in  = dot_sum_ff;
      xsq_in      = xsq_ff;
      ysq_in      = ysq_ff;
      count_in    = count_ff;
      ovf_seen_in = ovf_seen_ff;
      if (cmd.load) begin
         dot_sum_in  = '0;
         xsq_in      = '0;
         ysq_in      = '0;
         count_in    = '0;
         ovf_seen_in = 1'b0;
      end else if (s1_valid_ff) begin
         if (count_ff >= MaxCount) begin
            ovf_seen_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (dot_wide[AccW] != dot_wide[AccW-1]) begin
               dot_sum_in = {dot_wide[AccW], {(AccW - 1){~dot_wide[AccW]}}};
            end else begin
               dot_sum_in = dot_wide[AccW-1:0];
            end
            xsq_in = xsq_wide[AccW] ? {AccW{1'b1}} : xsq_wide[AccW-1:0];
            ysq_in = ysq_wide[AccW] ? {AccW{1'b1}} : ysq_wide[AccW-1:0];
         end
      end
   end

   // shift-add multiplier, then the product is consumed two bits at a time by the root
   always_comb begin
      sq_try   = {sqrem_ff[SqRemW-3:0], prod_ff[ProdW-1:ProdW-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      prod_in  = prod_ff;
      root_in  = root_ff;
      sqrem_in = sqrem_ff;
      if (cmd.load) begin
         ma_in    = xsq_ff;
         mb_in    = ysq_ff;
         prod_in  = '0;
         root_in  = '0;
         sqrem_in = '0;
      end else if (cmd.mul_step) begin
         prod_in = {prod_ff[ProdW-2:0], 1'b0}
                   + (mb_ff[AccW-1] ? {{(ProdW - AccW){1'b0}}, ma_ff} : '0);
         mb_in   = {mb_ff[AccW-2:0], 1'b0};
      end else if (cmd.sqrt_step) begin
         prod_in = {prod_ff[ProdW-3:0], 2'b00};
         if (sq_try >= sq_trial) begin
            sqrem_in = sq_try - sq_trial;
            root_in  = {root_ff[AccW-2:0], 1'b1};
         end else begin
            sqrem_in = sq_try;
            root_in  = {root_ff[AccW-2:0], 1'b0};
         end
      end
   end

   // restoring division of the dot magnitude by the root, one quotient bit a step
   always_comb begin
      div_try = {drem_ff, 1'b0};
      div_den = {1'b0, root_ff};
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      drem_in = drem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (cmd.load) begin
         neg_in  = dot_sum_ff[AccW-1];
         mag_in  = dot_sum_ff[AccW-1] ? AccW'(-dot_sum_ff) : dot_sum_ff;
         drem_in = dot_sum_ff[AccW-1] ? AccW'(-dot_sum_ff) : dot_sum_ff;
         q_in    = '0;
         ovf_in  = ovf_seen_ff;
      end else if (cmd.div_step) begin
         if (div_try >= div_den) begin
            drem_in = AccW'(div_try - div_den);
            q_in    = {q_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            drem_in = div_try[AccW-1:0];
            q_in    = {q_ff[FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   // quotient of one or more clamps to one
   always_comb begin
      q_full   = (mag_ff >= root_ff) ? QOne : {1'b0, q_ff};
      sim_full = neg_ff ? -$signed(SimW'(q_full)) : $signed(SimW'(q_full));
      sim_in   = sim_ff;
      zero_in  = zero_ff;
      ovfo_in  = ovfo_ff;
      if (cmd.result_load) begin
         zero_in = (root_ff == '0);
         sim_in  = (root_ff == '0) ? '0 : sim_full[OutW-1:0];
         ovfo_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         dot_sum_ff  <= '0;
         xsq_ff      <= '0;
         ysq_ff      <= '0;
         count_ff    <= '0;
         ovf_seen_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         dot_sum_ff  <= dot_sum_in;
         xsq_ff      <= xsq_in;
         ysq_ff      <= ysq_in;
         count_ff    <= count_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dot_ff <= s1_dot_in;
      s1_xx_ff  <= s1_xx_in;
      s1_yy_ff  <= s1_yy_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      root_ff   <= root_in;
      sqrem_ff  <= sqrem_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      drem_ff   <= drem_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
      sim_ff    <= sim_in;
      zero_ff   <= zero_in;
      ovfo_ff   <= ovfo_in;
   end

   assign similarity = sim_ff;
   assign zero_norm  = zero_ff;
   assign overflow   = ovfo_ff;

endmodule

### rtl/csu_checker.sv
// port-level checker of the cosine similarity unit and its bind
`include "cosine_similarity_unit_macros.svh"

module csu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [csu_pkg::OutW-1:0]      similarity
);

   // the back end takes over right after a final pair
   `CSU_ASSERT(a_last_stops_input, clock, reset, req_valid && req_ready && req_last |=> !req_ready, "input still open after last transaction")

   // a new result only comes out of the back end, never while input is open
   `CSU_ASSERT(a_result_from_back_end, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "result raised while input was open")

   `CSU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(similarity), "stalled result changed")

   `CSU_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .similarity (rsp_chan.similarity)
);
